// File: hw/rtl/svlf_pkg.sv
// svlf_pkg: shared types, field widths and codes for the semantic voxel label fusion block
// no dependencies; imported by the interfaces and every module of the block
package svlf_pkg;

    localparam int KIND_W     = 2;
    localparam int LABEL_W    = 5;
    localparam int ADDR_W     = 12;
    localparam int DIST_W     = 16;
    localparam int LOGP_W     = 16;
    localparam int TRUNC_W    = 15;
    localparam int PROB_W     = 32;
    localparam int COUNT_W    = 16;
    localparam int DIFF_W     = LOGP_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic signed [LOGP_W-1:0] LOG_MATCH_RST    = -16'sd27;
    localparam logic signed [LOGP_W-1:0] LOG_NONMATCH_RST = -16'sd589;
    localparam logic [TRUNC_W-1:0]       TRUNC_RST        = 15'd512;

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR = 2'd0,
        KIND_ADD   = 2'd1,
        KIND_APPLY = 2'd2
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOG_MATCH    = 2'd0,
        REG_LOG_NONMATCH = 2'd1,
        REG_TRUNC        = 2'd2
    } cfg_reg_t;

    // histogram commands from the sequencer
    typedef struct packed {
        logic               clear;
        logic               add;
        logic [LABEL_W-1:0] label;
    } hist_req_t;

endpackage

// File: hw/rtl/svlf_if.sv
// svlf_if: valid/ready channel interfaces for items, results and register writes
// depends on svlf_pkg for field widths
interface svlf_item_if import svlf_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic [LABEL_W-1:0]       meas_label;
    logic [ADDR_W-1:0]        voxel_addr;
    logic signed [DIST_W-1:0] signed_distance;

    modport source (output valid, kind, meas_label, voxel_addr, signed_distance,
                    input ready);
    modport sink (input valid, kind, meas_label, voxel_addr, signed_distance,
                  output ready);
endinterface

interface svlf_result_if import svlf_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [ADDR_W-1:0]        out_voxel;
    logic [LABEL_W-1:0]       best_label;
    logic signed [PROB_W-1:0] best_log_prob;
    logic                     was_updated;

    modport source (output valid, out_voxel, best_label, best_log_prob, was_updated,
                    input ready);
    modport sink (input valid, out_voxel, best_label, best_log_prob, was_updated,
                  output ready);
endinterface

interface svlf_cfg_if import svlf_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/svlf_hist.sv
// svlf_hist: measured-label histogram memory with per-label valid bits and running total
// depends on svlf_pkg (hist_req_t, COUNT_W, COUNT_MAX)
module svlf_hist import svlf_pkg::*; #(
    parameter int NUM_LABELS = 32,
    parameter int LBL_W      = 5,
    parameter int TOT_W      = 21
) (
    input  logic               clk,
    input  logic               rst_n,
    input  hist_req_t          req,
    input  logic               rd_en,
    input  logic [LBL_W-1:0]   rd_idx,
    output logic [COUNT_W-1:0] count,
    output logic [TOT_W-1:0]   total
);

    logic [COUNT_W-1:0]    cnt_mem [NUM_LABELS];
    logic [COUNT_W-1:0]    mem_q_reg;
    logic                  vq_reg;
    logic [NUM_LABELS-1:0] valid_reg;
    logic [TOT_W-1:0]      total_reg;
    logic                  add_pend_reg;
    logic [LBL_W-1:0]      add_idx_reg;

    logic                  lbl_ok;
    logic [LBL_W-1:0]      lbl_idx;
    logic [LBL_W-1:0]      ra;
    logic                  re;
    logic [COUNT_W-1:0]    cur;
    logic                  bump;

    assign lbl_ok  = 32'(req.label) < NUM_LABELS;
    assign lbl_idx = LBL_W'(req.label);
    assign re      = req.add || rd_en;
    assign ra      = req.add ? lbl_idx : rd_idx;

    // entries not written since the last clear read as zero
    assign cur   = vq_reg ? mem_q_reg : '0;
    assign bump  = add_pend_reg && (cur != COUNT_MAX);
    assign count = cur;
    assign total = total_reg;

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            mem_q_reg <= cnt_mem[ra];
            vq_reg    <= valid_reg[ra];
        end
        if (bump)
        begin
            cnt_mem[add_idx_reg] <= cur + COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            total_reg    <= '0;
            add_pend_reg <= 1'b0;
            add_idx_reg  <= '0;
        end
        else
        begin
            add_pend_reg <= req.add && lbl_ok;
            add_idx_reg  <= lbl_idx;
            if (req.clear)
            begin
                valid_reg <= '0;
                total_reg <= '0;
            end
            else if (bump)
            begin
                valid_reg[add_idx_reg] <= 1'b1;
                total_reg              <= total_reg + TOT_W'(1);
            end
        end
    end

endmodule

// File: hw/rtl/svlf_mac.sv
// svlf_mac: shared multiply / accumulate / saturate unit, one label per cycle
// depends on svlf_pkg (DIFF_W, PROB_W)
module svlf_mac import svlf_pkg::*; #(
    parameter int TOT_W  = 21,
    parameter int PROD_W = DIFF_W + TOT_W + 1
) (
    input  logic                     clk,
    input  logic signed [DIFF_W-1:0] mul_a,
    input  logic [TOT_W-1:0]         mul_b,
    input  logic signed [PROB_W-1:0] prob_in,
    input  logic signed [PROD_W-1:0] base,
    output logic signed [PROD_W-1:0] prod,
    output logic signed [PROB_W-1:0] sum
);

    localparam int ACC_W = PROD_W + 2;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROB_W-1:0] prob_d_reg;
    logic signed [PROB_W-1:0] sum_reg;
    logic signed [ACC_W-1:0]  sum_full;
    logic signed [PROB_W-1:0] sum_sat;

    assign sum_full = ACC_W'(prob_d_reg) + ACC_W'(base) + ACC_W'(prod_reg);

    always_comb
    begin
        // upper bits all equal means the sum fits in 32 bits
        if ((sum_full[ACC_W-1:PROB_W-1] == '0) || (sum_full[ACC_W-1:PROB_W-1] == '1))
        begin
            sum_sat = sum_full[PROB_W-1:0];
        end
        else if (sum_full[ACC_W-1])
        begin
            sum_sat = {1'b1, {(PROB_W-1){1'b0}}};
        end
        else
        begin
            sum_sat = {1'b0, {(PROB_W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= PROD_W'(mul_a) * PROD_W'($signed({1'b0, mul_b}));
        prob_d_reg <= prob_in;
        sum_reg    <= sum_sat;
    end

    assign prod = prod_reg;
    assign sum  = sum_reg;

endmodule

// File: hw/rtl/semantic_voxel_label_fusion.sv
// semantic_voxel_label_fusion: voxel log-probability store, sequencer and result register
// an updating apply runs S_SETUP, S_BASE and the label walk S_WALK (one label per cycle
// through svlf_mac, bound by the probability memory ports); a non-updating apply in range
// reads through S_RDPROB and S_RDWAIT, an add passes S_ADD, a clear stays in S_IDLE; one
// item at a time, the result word sits in an output register so the next item is taken
// while it waits, a second one waits for it; after reset S_INIT zeroes the stores, no item taken
module semantic_voxel_label_fusion import svlf_pkg::*; #(
    parameter int NUM_LABELS = 32,
    parameter int NUM_VOXELS = 4096
) (
    input logic            clk,
    input logic            rst_n,
    svlf_cfg_if.sink       cfg,
    svlf_item_if.sink      item,
    svlf_result_if.source  result
);

    localparam int LBL_W  = $clog2(NUM_LABELS);
    localparam int VOX_W  = (NUM_VOXELS > 1) ? $clog2(NUM_VOXELS) : 1;
    localparam int DEPTH  = NUM_VOXELS * NUM_LABELS;
    localparam int PW     = $clog2(DEPTH);
    localparam int TOT_W  = COUNT_W + LBL_W;
    localparam int PROD_W = DIFF_W + TOT_W + 1;

    localparam logic [LBL_W-1:0] LAST_LBL  = LBL_W'(NUM_LABELS - 1);
    localparam logic [PW-1:0]    LAST_ADDR = PW'(DEPTH - 1);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_ADD,
        S_SETUP,
        S_BASE,
        S_WALK,
        S_RDPROB,
        S_RDWAIT,
        S_DONE
    } state_t;

    // memories
    logic signed [PROB_W-1:0] prob_mem [DEPTH];
    logic [LBL_W-1:0]         best_mem [NUM_VOXELS];
    logic signed [PROB_W-1:0] prob_q_reg;
    logic [LBL_W-1:0]         best_q_reg;

    logic                     prob_we;
    logic [PW-1:0]            prob_wa;
    logic signed [PROB_W-1:0] prob_wd;
    logic                     prob_re;
    logic [PW-1:0]            prob_ra;
    logic                     best_we;
    logic [VOX_W-1:0]         best_wa;
    logic [LBL_W-1:0]         best_wd;
    logic                     best_re;

    // control and datapath registers
    state_t                   state_reg, state_next;
    logic signed [LOGP_W-1:0] match_reg, match_next;
    logic signed [LOGP_W-1:0] nonmatch_reg, nonmatch_next;
    logic [TRUNC_W-1:0]       trunc_reg, trunc_next;
    logic [ADDR_W-1:0]        addr_reg, addr_next;
    logic signed [DIST_W-1:0] dist_reg, dist_next;
    logic [PW-1:0]            row_base_reg, row_base_next;
    logic signed [DIFF_W-1:0] diff_reg, diff_next;
    logic signed [PROD_W-1:0] base_reg, base_next;
    logic [LBL_W-1:0]         idx_reg, idx_next;
    logic                     issue_reg, issue_next;
    logic                     s1_v_reg, s1_v_next;
    logic                     s2_v_reg, s2_v_next;
    logic                     s3_v_reg, s3_v_next;
    logic [LBL_W-1:0]         s1_idx_reg, s1_idx_next;
    logic [LBL_W-1:0]         s2_idx_reg, s2_idx_next;
    logic [LBL_W-1:0]         s3_idx_reg, s3_idx_next;
    logic [LBL_W-1:0]         best_idx_reg, best_idx_next;
    logic signed [PROB_W-1:0] best_val_reg, best_val_next;
    logic [LBL_W-1:0]         res_label_reg, res_label_next;
    logic signed [PROB_W-1:0] res_val_reg, res_val_next;
    logic                     res_upd_reg, res_upd_next;
    logic [PW-1:0]            clr_addr_reg, clr_addr_next;
    logic [VOX_W-1:0]         clr_vox_reg, clr_vox_next;
    logic                     out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]        out_voxel_reg, out_voxel_next;
    logic [LABEL_W-1:0]       out_label_reg, out_label_next;
    logic signed [PROB_W-1:0] out_prob_reg, out_prob_next;
    logic                     out_upd_reg, out_upd_next;

    // shared unit and histogram hookup
    hist_req_t                hreq;
    logic                     hist_rd;
    logic [COUNT_W-1:0]       hist_count;
    logic [TOT_W-1:0]         hist_total;
    logic signed [DIFF_W-1:0] mul_a;
    logic [TOT_W-1:0]         mul_b;
    logic signed [PROD_W-1:0] mac_prod;
    logic signed [PROB_W-1:0] mac_sum;

    logic [VOX_W-1:0]         vox_idx;
    logic                     in_range;
    logic [DIST_W:0]          dist_ext;
    logic [DIST_W:0]          dist_mag;
    logic                     gate_open;
    logic                     take_new;
    logic [LBL_W-1:0]         fin_idx;
    logic signed [PROB_W-1:0] fin_val;

    svlf_hist #(
        .NUM_LABELS (NUM_LABELS),
        .LBL_W      (LBL_W),
        .TOT_W      (TOT_W)
    ) u_hist (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (hreq),
        .rd_en  (hist_rd),
        .rd_idx (idx_reg),
        .count  (hist_count),
        .total  (hist_total)
    );

    svlf_mac #(
        .TOT_W  (TOT_W),
        .PROD_W (PROD_W)
    ) u_mac (
        .clk     (clk),
        .mul_a   (mul_a),
        .mul_b   (mul_b),
        .prob_in (prob_q_reg),
        .base    (base_reg),
        .prod    (mac_prod),
        .sum     (mac_sum)
    );

    // the multiplier forms log_nonmatch * N once, then diff * count_i per label
    assign mul_a = (state_reg == S_SETUP) ? DIFF_W'(nonmatch_reg) : diff_reg;
    assign mul_b = (state_reg == S_SETUP) ? hist_total : TOT_W'(hist_count);

    assign vox_idx   = VOX_W'(addr_reg);
    assign in_range  = 32'(addr_reg) < NUM_VOXELS;
    assign dist_ext  = {dist_reg[DIST_W-1], dist_reg};
    assign dist_mag  = dist_reg[DIST_W-1] ? (~dist_ext + (DIST_W+1)'(1)) : dist_ext;
    assign gate_open = dist_mag < (DIST_W+1)'(trunc_reg);

    // strict compare keeps the lowest index on ties
    assign take_new = (s3_idx_reg == '0) || (mac_sum > best_val_reg);
    assign fin_idx  = take_new ? s3_idx_reg : best_idx_reg;
    assign fin_val  = take_new ? mac_sum : best_val_reg;

    assign cfg.ready            = 1'b1;
    assign item.ready           = (state_reg == S_IDLE);
    assign result.valid         = out_valid_reg;
    assign result.out_voxel     = out_voxel_reg;
    assign result.best_label    = out_label_reg;
    assign result.best_log_prob = out_prob_reg;
    assign result.was_updated   = out_upd_reg;

    always_comb
    begin
        state_next     = state_reg;
        match_next     = match_reg;
        nonmatch_next  = nonmatch_reg;
        trunc_next     = trunc_reg;
        addr_next      = addr_reg;
        dist_next      = dist_reg;
        row_base_next  = row_base_reg;
        diff_next      = diff_reg;
        base_next      = base_reg;
        idx_next       = idx_reg;
        issue_next     = issue_reg;
        s1_v_next      = 1'b0;
        s1_idx_next    = idx_reg;
        s2_v_next      = s1_v_reg;
        s2_idx_next    = s1_idx_reg;
        s3_v_next      = s2_v_reg;
        s3_idx_next    = s2_idx_reg;
        best_idx_next  = best_idx_reg;
        best_val_next  = best_val_reg;
        res_label_next = res_label_reg;
        res_val_next   = res_val_reg;
        res_upd_next   = res_upd_reg;
        clr_addr_next  = clr_addr_reg;
        clr_vox_next   = clr_vox_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_voxel_next = out_voxel_reg;
        out_label_next = out_label_reg;
        out_prob_next  = out_prob_reg;
        out_upd_next   = out_upd_reg;

        prob_we = 1'b0;
        prob_wa = '0;
        prob_wd = '0;
        prob_re = 1'b0;
        prob_ra = '0;
        best_we = 1'b0;
        best_wa = vox_idx;
        best_wd = '0;
        best_re = 1'b0;
        hreq    = '0;
        hist_rd = 1'b0;

        if (cfg.valid)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_LOG_MATCH:    match_next    = cfg.data;
                REG_LOG_NONMATCH: nonmatch_next = cfg.data;
                REG_TRUNC:        trunc_next    = cfg.data[TRUNC_W-1:0];
                default:          ;
            endcase
        end

        unique case (state_reg)
            S_INIT:
            begin
                prob_we = 1'b1;
                prob_wa = clr_addr_reg;
                best_we = 1'b1;
                best_wa = clr_vox_reg;
                if (clr_addr_reg == LAST_ADDR)
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + PW'(1);
                    if (idx_reg == LAST_LBL)
                    begin
                        idx_next     = '0;
                        clr_vox_next = clr_vox_reg + VOX_W'(1);
                    end
                    else
                    begin
                        idx_next = idx_reg + LBL_W'(1);
                    end
                end
            end

            S_IDLE:
            begin
                if (item.valid)
                begin
                    unique case (kind_t'(item.kind))
                        KIND_CLEAR:
                        begin
                            hreq.clear = 1'b1;
                        end
                        KIND_ADD:
                        begin
                            hreq.add   = 1'b1;
                            hreq.label = item.meas_label;
                            state_next = S_ADD;
                        end
                        KIND_APPLY:
                        begin
                            addr_next  = item.voxel_addr;
                            dist_next  = item.signed_distance;
                            state_next = S_SETUP;
                        end
                        default: ;
                    endcase
                end
            end

            // histogram write-back of the pending add
            S_ADD:
            begin
                state_next = S_IDLE;
            end

            S_SETUP:
            begin
                best_re       = 1'b1;
                row_base_next = PW'(32'(addr_reg) * NUM_LABELS);
                diff_next     = $signed({match_reg[LOGP_W-1], match_reg})
                              - $signed({nonmatch_reg[LOGP_W-1], nonmatch_reg});
                res_label_next = '0;
                res_val_next   = '0;
                res_upd_next   = 1'b0;
                if (!in_range)
                begin
                    state_next = S_DONE;
                end
                else if (gate_open && (hist_total != '0))
                begin
                    state_next = S_BASE;
                end
                else
                begin
                    state_next = S_RDPROB;
                end
            end

            S_BASE:
            begin
                base_next  = mac_prod;
                idx_next   = '0;
                issue_next = 1'b1;
                state_next = S_WALK;
            end

            S_WALK:
            begin
                if (issue_reg)
                begin
                    prob_re   = 1'b1;
                    prob_ra   = row_base_reg + PW'(idx_reg);
                    hist_rd   = 1'b1;
                    s1_v_next = 1'b1;
                    if (idx_reg == LAST_LBL)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        idx_next = idx_reg + LBL_W'(1);
                    end
                end
                if (s3_v_reg)
                begin
                    prob_we       = 1'b1;
                    prob_wa       = row_base_reg + PW'(s3_idx_reg);
                    prob_wd       = mac_sum;
                    best_idx_next = fin_idx;
                    best_val_next = fin_val;
                    if (s3_idx_reg == LAST_LBL)
                    begin
                        best_we        = 1'b1;
                        best_wd        = fin_idx;
                        res_label_next = fin_idx;
                        res_val_next   = fin_val;
                        res_upd_next   = 1'b1;
                        state_next     = S_DONE;
                    end
                end
            end

            S_RDPROB:
            begin
                prob_re    = 1'b1;
                prob_ra    = row_base_reg + PW'(best_q_reg);
                state_next = S_RDWAIT;
            end

            S_RDWAIT:
            begin
                res_label_next = best_q_reg;
                res_val_next   = prob_q_reg;
                res_upd_next   = 1'b0;
                state_next     = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_voxel_next = addr_reg;
                    out_label_next = LABEL_W'(res_label_reg);
                    out_prob_next  = res_val_reg;
                    out_upd_next   = res_upd_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (prob_we)
        begin
            prob_mem[prob_wa] <= prob_wd;
        end
        if (prob_re)
        begin
            prob_q_reg <= prob_mem[prob_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (best_we)
        begin
            best_mem[best_wa] <= best_wd;
        end
        if (best_re)
        begin
            best_q_reg <= best_mem[vox_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            match_reg     <= LOG_MATCH_RST;
            nonmatch_reg  <= LOG_NONMATCH_RST;
            trunc_reg     <= TRUNC_RST;
            addr_reg      <= '0;
            dist_reg      <= '0;
            row_base_reg  <= '0;
            diff_reg      <= '0;
            base_reg      <= '0;
            idx_reg       <= '0;
            issue_reg     <= 1'b0;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            s3_v_reg      <= 1'b0;
            s1_idx_reg    <= '0;
            s2_idx_reg    <= '0;
            s3_idx_reg    <= '0;
            best_idx_reg  <= '0;
            best_val_reg  <= '0;
            res_label_reg <= '0;
            res_val_reg   <= '0;
            res_upd_reg   <= 1'b0;
            clr_addr_reg  <= '0;
            clr_vox_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_voxel_reg <= '0;
            out_label_reg <= '0;
            out_prob_reg  <= '0;
            out_upd_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            match_reg     <= match_next;
            nonmatch_reg  <= nonmatch_next;
            trunc_reg     <= trunc_next;
            addr_reg      <= addr_next;
            dist_reg      <= dist_next;
            row_base_reg  <= row_base_next;
            diff_reg      <= diff_next;
            base_reg      <= base_next;
            idx_reg       <= idx_next;
            issue_reg     <= issue_next;
            s1_v_reg      <= s1_v_next;
            s2_v_reg      <= s2_v_next;
            s3_v_reg      <= s3_v_next;
            s1_idx_reg    <= s1_idx_next;
            s2_idx_reg    <= s2_idx_next;
            s3_idx_reg    <= s3_idx_next;
            best_idx_reg  <= best_idx_next;
            best_val_reg  <= best_val_next;
            res_label_reg <= res_label_next;
            res_val_reg   <= res_val_next;
            res_upd_reg   <= res_upd_next;
            clr_addr_reg  <= clr_addr_next;
            clr_vox_reg   <= clr_vox_next;
            out_valid_reg <= out_valid_next;
            out_voxel_reg <= out_voxel_next;
            out_label_reg <= out_label_next;
            out_prob_reg  <= out_prob_next;
            out_upd_reg   <= out_upd_next;
        end
    end

    // no label still in flight when a new word can be taken
    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        item.ready |-> !(s1_v_reg || s2_v_reg || s3_v_reg || issue_reg))
        else $error("label pipeline busy while taking a new word");

    // write-back stage only runs inside the label walk
    a_wb_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        s3_v_reg |-> (state_reg == S_WALK))
        else $error("probability write-back outside the label walk");

    // a pending result word is never overwritten
    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && !result.ready) |=> (state_reg == S_DONE))
        else $error("result register reloaded while still full");

    // every written-back label index is a real label
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        s3_v_reg |-> (32'(s3_idx_reg) < NUM_LABELS))
        else $error("label index out of range in write-back");

endmodule

// File: test/svlf_fusion_checker.sv
// svlf_fusion_checker: watches the register, item and result channels of the label fusion
// block, keeps its own copy of histogram, voxel store and registers, and compares each result
// depends on svlf_pkg and the channel interfaces in svlf_if
`timescale 1ns / 1ps

module svlf_fusion_checker import svlf_pkg::*; #(
    parameter int NUM_LABELS = 32,
    parameter int NUM_VOXELS = 4096
) (
    input logic    clk,
    input logic    rst_n,
    svlf_cfg_if    cfg,
    svlf_item_if   item,
    svlf_result_if result,
    output int     fail_count,
    output int     pending
);

    localparam longint LOGP_CEIL  = 64'sd2147483647;
    localparam longint LOGP_FLOOR = -64'sd2147483648;

    typedef struct packed {
        logic [ADDR_W-1:0]        voxel;
        logic [LABEL_W-1:0]       label;
        logic signed [PROB_W-1:0] logp;
        logic                     updated;
    } voxel_report_t;

    voxel_report_t reports_due[$];

    int logp_store [NUM_VOXELS*NUM_LABELS];
    int ml_label   [NUM_VOXELS];
    int label_hist [NUM_LABELS];
    int w_match;
    int w_nonmatch;
    int w_trunc;

    task automatic fuse_item(input logic [KIND_W-1:0] k, input logic [LABEL_W-1:0] lbl,
                             input logic [ADDR_W-1:0] addr,
                             input logic signed [DIST_W-1:0] sdist);
        longint        total;
        longint        base;
        longint        diff;
        longint        acc;
        int            mag;
        int            best;
        int            a;
        int            row;
        bit            upd;
        voxel_report_t rep;
        case (k)
            KIND_CLEAR: foreach (label_hist[i]) label_hist[i] = 0;
            KIND_ADD:
                if (int'(lbl) < NUM_LABELS && label_hist[lbl] < int'(COUNT_MAX))
                    label_hist[lbl] = label_hist[lbl] + 1;
            KIND_APPLY:
            begin
                a = int'(addr);
                rep.voxel = addr;
                rep.label = '0;
                rep.logp = '0;
                rep.updated = 1'b0;
                if (a < NUM_VOXELS)
                begin
                    row = a * NUM_LABELS;
                    total = 0;
                    foreach (label_hist[i]) total += label_hist[i];
                    mag = (sdist < 0) ? -int'(sdist) : int'(sdist);
                    upd = (mag < w_trunc) && (total != 0);
                    if (upd)
                    begin
                        base = longint'(w_nonmatch) * total;
                        diff = longint'(w_match) - longint'(w_nonmatch);
                        best = 0;
                        foreach (label_hist[i])
                        begin
                            acc = longint'(logp_store[row + i]) + base + diff * label_hist[i];
                            if (acc < LOGP_FLOOR)
                                acc = LOGP_FLOOR;
                            else if (acc > LOGP_CEIL)
                                acc = LOGP_CEIL;
                            logp_store[row + i] = int'(acc);
                            // strict compare keeps the lowest label on ties
                            if (logp_store[row + i] > logp_store[row + best])
                                best = i;
                        end
                        ml_label[a] = best;
                    end
                    rep.label = LABEL_W'(ml_label[a]);
                    rep.logp = logp_store[row + ml_label[a]];
                    rep.updated = upd;
                end
                reports_due.push_back(rep);
            end
            default: ;
        endcase
    endtask

    task automatic check_report();
        voxel_report_t want;
        if (reports_due.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("unexpected result word: voxel %0d label %0d log prob %0d updated %0b",
                         result.out_voxel, result.best_label, result.best_log_prob,
                         result.was_updated);
        end
        else
        begin
            want = reports_due.pop_front();
            if (result.out_voxel !== want.voxel || result.best_label !== want.label ||
                result.best_log_prob !== want.logp || result.was_updated !== want.updated)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display(
                        "mismatch exp/act: voxel %0d/%0d label %0d/%0d logp %0d/%0d upd %0b/%0b",
                        want.voxel, result.out_voxel, want.label, result.best_label,
                        want.logp, result.best_log_prob, want.updated,
                        result.was_updated);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_match = LOG_MATCH_RST;
            w_nonmatch = LOG_NONMATCH_RST;
            w_trunc = TRUNC_RST;
            foreach (logp_store[i]) logp_store[i] = 0;
            foreach (ml_label[i]) ml_label[i] = 0;
            foreach (label_hist[i]) label_hist[i] = 0;
            reports_due.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            // results always stem from earlier words, so check before predicting
            if (result.valid && result.ready)
                check_report();
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_LOG_MATCH:    w_match = $signed(cfg.data);
                    REG_LOG_NONMATCH: w_nonmatch = $signed(cfg.data);
                    REG_TRUNC:        w_trunc = int'(cfg.data[TRUNC_W-1:0]);
                    default: ;
                endcase
            end
            if (item.valid && item.ready)
                fuse_item(item.kind, item.meas_label, item.voxel_addr,
                          item.signed_distance);
            pending = reports_due.size();
        end
    end

endmodule

// File: test/testbench.sv
// testbench: drives items and register writes into semantic_voxel_label_fusion with bursty
// traffic and a stalling result receiver; svlf_fusion_checker does prediction and compare
// depends on svlf_pkg, svlf_if, the block and svlf_fusion_checker
`timescale 1ns / 1ps

module testbench;
    import svlf_pkg::*;

    localparam int CYCLE_LIMIT    = 2000000;
    localparam int SETTLE_CYCLES  = 50;
    localparam int LONG_HOLD_OFF  = 400;
    localparam int PHASE_ITEMS    = 110;
    localparam int SAT_ADDS       = 256;
    localparam int FLOOR_APPLIES  = 260;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef enum int {RX_OPEN, RX_HALF, RX_SPARSE, RX_PERIODIC} rx_mode_t;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   reports_pending;
    int   burst_left;
    int   cur_trunc;
    int   cycles;
    bit   long_stall_req;

    svlf_cfg_if    cfg_ch();
    svlf_item_if   item_ch();
    svlf_result_if result_ch();

    semantic_voxel_label_fusion u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .item   (item_ch),
        .result (result_ch)
    );

    svlf_fusion_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_ch),
        .item       (item_ch),
        .result     (result_ch),
        .fail_count (fail_count),
        .pending    (reports_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial cycles = 0;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("semantic_voxel_label_fusion verification failed");
            $finish;
        end
    end

    // valid stays high across a burst; a gap follows when the burst runs out
    task automatic send_item(input logic [KIND_W-1:0] k, input logic [LABEL_W-1:0] lbl,
                             input logic [ADDR_W-1:0] addr, input logic [DIST_W-1:0] sdist);
        item_ch.valid <= 1'b1;
        item_ch.kind <= k;
        item_ch.meas_label <= lbl;
        item_ch.voxel_addr <= addr;
        item_ch.signed_distance <= sdist;
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 6);
        end
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] d);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= d;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
    endtask

    task automatic load_settings(input logic [CFG_DATA_W-1:0] m, input logic [CFG_DATA_W-1:0] nm,
                                 input logic [CFG_DATA_W-1:0] tr);
        write_reg(REG_LOG_MATCH, m);
        write_reg(REG_LOG_NONMATCH, nm);
        write_reg(REG_TRUNC, tr);
        cfg_ch.valid <= 1'b0;
        cur_trunc = int'(tr[TRUNC_W-1:0]);
    endtask

    // wait for every result, then let a trailing add or clear finish
    task automatic drain();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (reports_pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [ADDR_W-1:0] pick_voxel();
        if ($urandom_range(0, 3) == 0)
            return ADDR_W'($urandom_range(0, 4095));
        return ADDR_W'($urandom_range(0, 15));
    endfunction

    function automatic logic [DIST_W-1:0] pick_dist();
        int d;
        if (cur_trunc > 0 && $urandom_range(0, 3) != 0)
        begin
            d = $urandom_range(0, cur_trunc - 1);
            if ($urandom_range(0, 1) == 1)
                d = -d;
            return DIST_W'(d);
        end
        return DIST_W'($urandom_range(0, 65535));
    endfunction

    // result receiver: stall pattern by segments, plus one long hold-off on request
    initial
    begin
        int       seg_left;
        rx_mode_t mode;
        result_ch.ready <= 1'b0;
        seg_left = 0;
        mode = RX_OPEN;
        forever
        begin
            @(posedge clk);
            if (long_stall_req)
            begin
                long_stall_req = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD_OFF) @(posedge clk);
            end
            else
            begin
                if (seg_left == 0)
                begin
                    mode = rx_mode_t'($urandom_range(0, 3));
                    seg_left = $urandom_range(10, 80);
                end
                seg_left--;
                case (mode)
                    RX_OPEN:   result_ch.ready <= 1'b1;
                    RX_HALF:   result_ch.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: result_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:   result_ch.ready <= ((seg_left % 16) < 4);
                endcase
            end
        end
    end

    initial
    begin
        int phase;
        int sent;
        int n;
        int napply;
        int r;
        int m;
        int nm;
        int tr;
        logic [LABEL_W-1:0] hot;

        rst_n <= 1'b0;
        item_ch.valid <= 1'b0;
        item_ch.kind <= KIND_CLEAR;
        item_ch.meas_label <= '0;
        item_ch.voxel_addr <= '0;
        item_ch.signed_distance <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= REG_LOG_MATCH;
        cfg_ch.data <= '0;
        burst_left = 0;
        cur_trunc = TRUNC_RST;
        long_stall_req = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: empty histogram, unused kind, gate edges, tie on labels
        send_item(KIND_APPLY, '1, 12'd0, 16'd0);
        send_item(KIND_UNUSED, '1, '1, '1);
        send_item(KIND_ADD, 5'd0, '1, '1);
        send_item(KIND_ADD, 5'd31, '0, '0);
        send_item(KIND_ADD, 5'd31, '0, '0);
        send_item(KIND_ADD, 5'd5, '0, '0);
        send_item(KIND_APPLY, '0, 12'd4095, 16'd511);
        send_item(KIND_APPLY, '0, 12'd4095, -16'sd512);
        send_item(KIND_APPLY, '0, 12'd4095, 16'h8000);
        send_item(KIND_APPLY, '0, 12'd0, 16'h7FFF);
        send_item(KIND_APPLY, '0, 12'd1, -16'sd511);
        send_item(KIND_CLEAR, '1, '1, '1);
        send_item(KIND_APPLY, '0, 12'd1, 16'd0);
        send_item(KIND_ADD, 5'd9, '0, '0);
        send_item(KIND_ADD, 5'd3, '0, '0);
        send_item(KIND_APPLY, '0, 12'd3, 16'd0);
        drain();

        // one label counted heavily, then repeated applies push sums to the signed floor
        load_settings(16'h0000, 16'h8000, 16'hFFFF);
        send_item(KIND_CLEAR, '0, '0, '0);
        burst_left = SAT_ADDS + FLOOR_APPLIES + 10;
        repeat (SAT_ADDS) send_item(KIND_ADD, 5'd17, '0, '0);
        repeat (FLOOR_APPLIES) send_item(KIND_APPLY, '0, 12'd100, 16'd0);
        burst_left = 0;
        send_item(KIND_APPLY, '0, 12'd100, -16'sd32767);
        drain();

        // positive register values drive sums upward
        load_settings(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_item(KIND_APPLY, '0, 12'd101, 16'd0);
        send_item(KIND_APPLY, '0, 12'd101, 16'd0);
        send_item(KIND_APPLY, '0, 12'd100, 16'd0);
        drain();

        // zero gate: nothing can update
        load_settings(16'h8000, 16'h0000, 16'h0000);
        send_item(KIND_APPLY, '0, 12'd101, 16'd0);
        send_item(KIND_ADD, 5'd4, '0, '0);
        send_item(KIND_APPLY, '0, 12'd102, 16'd0);
        drain();

        for (phase = 0; phase < 6; phase++)
        begin
            if (phase == 5)
            begin
                m = LOG_MATCH_RST;
                nm = LOG_NONMATCH_RST;
                tr = TRUNC_RST;
            end
            else if (phase % 3 == 1)
            begin
                m = -int'($urandom_range(0, 32768));
                nm = -int'($urandom_range(0, 32768));
                tr = $urandom_range(0, 32767);
            end
            else
            begin
                m = -int'($urandom_range(0, 300));
                nm = -int'($urandom_range(300, 2000));
                tr = (phase == 2) ? $urandom_range(0, 32767) : $urandom_range(64, 2048);
            end
            load_settings(16'(m), 16'(nm), 16'(tr));
            if (phase == 2)
                long_stall_req = 1'b1;
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                r = $urandom_range(0, 9);
                if (r < 7)
                begin
                    // one observation: fresh histogram, labels clustered on one class
                    send_item(KIND_CLEAR, LABEL_W'($urandom), ADDR_W'($urandom),
                              DIST_W'($urandom));
                    n = $urandom_range(1, 12);
                    hot = LABEL_W'($urandom_range(0, 31));
                    repeat (n)
                        send_item(KIND_ADD,
                                  ($urandom_range(0, 2) == 0) ? LABEL_W'($urandom) : hot,
                                  ADDR_W'($urandom), DIST_W'($urandom));
                    napply = $urandom_range(1, 3);
                    repeat (napply)
                        send_item(KIND_APPLY, LABEL_W'($urandom), pick_voxel(), pick_dist());
                    sent += 1 + n + napply;
                end
                else if (r == 7)
                begin
                    send_item(KIND_APPLY, LABEL_W'($urandom), pick_voxel(), pick_dist());
                    sent++;
                end
                else if (r == 8)
                    send_item(KIND_UNUSED, LABEL_W'($urandom), ADDR_W'($urandom),
                              DIST_W'($urandom));
                else
                begin
                    send_item(KIND_ADD, LABEL_W'($urandom), ADDR_W'($urandom),
                              DIST_W'($urandom));
                    sent++;
                end
            end
            drain();
        end

        if (fail_count == 0 && reports_pending == 0)
            $display("semantic_voxel_label_fusion verification clean");
        else
            $display("semantic_voxel_label_fusion verification failed");
        $finish;
    end

endmodule
